// ----- rtl/edge_timed_uart_receiver_core_assert.svh -----
// ----------------------------------------------------------------------------
// Edge-timed UART receiver assertion macros
// Shared assertion forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef EDGE_TIMED_UART_RECEIVER_CORE_ASSERT_SVH
`define EDGE_TIMED_UART_RECEIVER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ETUR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("edge timed uart receiver check failed");

// The consequent must hold in the cycle after the antecedent.
`define ETUR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("edge timed uart receiver check failed");

`endif

// ----- rtl/etur_pkg.sv -----
// ----------------------------------------------------------------------------
// Edge-timed UART receiver package
// Stream widths, frame constants and command codes.
// ----------------------------------------------------------------------------
package etur_pkg;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;
  localparam int PERIOD_W    = 16;
  localparam int IDX_W       = 4;
  localparam int LEVEL_W     = 6;

  localparam logic [IDX_W-1:0]    FRAME_BITS   = 4'd10;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd104;

  // Ten bit periods of the longest setting fit in this width.
  localparam int ACC_W = 20;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_POP  = 1'b1;

endpackage

// ----- rtl/edge_timed_uart_receiver_core.sv -----
// ----------------------------------------------------------------------------
// Edge-timed UART receiver core
// An edge in a frame passes the subtract state, the ten-step bit count
// compare loop and the apply state; a pop passes the FIFO memory read, and
// an edge outside a frame goes straight to the output state. The next
// request is taken in the cycle after the output register is loaded, which
// waits out an output stall, so one request is through before the next.
// Reset is synchronous; the FIFO memory is not cleared and needs no pass.
// ----------------------------------------------------------------------------
module edge_timed_uart_receiver_core #(
  parameter int FIFO_DEPTH = 64,
  parameter int TIME_BITS  = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // line_level [0], event_time_us [32:1], zero fill
  input  logic [etur_pkg::IN_TDATA_W-1:0]   in_tdata,
  // cmd [0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // byte_value [7:0], fifo_level [13:8], overrun [14], zero fill
  output logic [etur_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // byte_valid [0]
  output logic                              out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [etur_pkg::PERIOD_W-1:0]     cfg_data
);
  import etur_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = (TIME_BITS + 1 > ACC_W) ? TIME_BITS + 1 : ACC_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(FIFO_DEPTH - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUB   = 3'd1;
  localparam logic [2:0] S_CNT   = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [7:0] fifo_mem [FIFO_DEPTH];
  logic [7:0] rd_data_r;

  logic [2:0]           state_r, state_nxt;
  logic [PERIOD_W-1:0]  period_r, period_nxt;
  logic                 active_r, active_nxt;
  logic [TIME_BITS-1:0] start_r, start_nxt;
  logic [IDX_W-1:0]     bit_idx_r, bit_idx_nxt;
  logic [7:0]           shift_r, shift_nxt;
  logic [AW-1:0]        head_r, head_nxt;
  logic [AW-1:0]        tail_r, tail_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic                 high_r, high_nxt;
  logic [TIME_BITS:0]   tph_r, tph_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [IDX_W-1:0]     k_r, k_nxt;
  logic [IDX_W-1:0]     target_r, target_nxt;
  logic [7:0]           res_byte_r, res_byte_nxt;
  logic                 res_valid_r, res_valid_nxt;
  logic                 res_ovr_r, res_ovr_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [7:0]           out_byte_r, out_byte_nxt;
  logic                 out_bvalid_r, out_bvalid_nxt;
  logic [LEVEL_W-1:0]   out_level_r, out_level_nxt;
  logic                 out_ovr_r, out_ovr_nxt;

  logic                 mem_we;
  logic [7:0]           mem_wdata;
  logic                 in_acc;
  logic [TIME_BITS+31:0] time_ext;
  logic [AW-1:0]        head_inc, tail_inc;
  logic [AW:0]          count;
  logic [AW+LEVEL_W:0]  count_ext;
  logic [7:0]           shift_upd;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_bvalid_r;
  assign out_tdata  = {1'b0, out_ovr_r, out_level_r, out_byte_r};

  assign time_ext = {{TIME_BITS{1'b0}}, in_tdata[32:1]};
  assign head_inc = (head_r == LAST_ADDR) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == LAST_ADDR) ? '0 : tail_r + 1'b1;

  always_comb begin
    count = {1'b0, head_r} - {1'b0, tail_r};
    if (head_r < tail_r) begin
      count = count + (AW+1)'(FIFO_DEPTH);
    end
    count_ext = (AW+LEVEL_W+1)'(count);
  end

  always_comb begin
    shift_upd = shift_r;
    for (int j = 0; j < 8; j++) begin
      if (!high_r && (4'(j + 1) >= bit_idx_r) && (4'(j + 1) < target_r)) begin
        shift_upd[j] = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    period_nxt     = period_r;
    active_nxt     = active_r;
    start_nxt      = start_r;
    bit_idx_nxt    = bit_idx_r;
    shift_nxt      = shift_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    now_nxt        = now_r;
    high_nxt       = high_r;
    tph_nxt        = tph_r;
    acc_nxt        = acc_r;
    k_nxt          = k_r;
    target_nxt     = target_r;
    res_byte_nxt   = res_byte_r;
    res_valid_nxt  = res_valid_r;
    res_ovr_nxt    = res_ovr_r;
    out_tvalid_nxt = out_tvalid_r;
    out_byte_nxt   = out_byte_r;
    out_bvalid_nxt = out_bvalid_r;
    out_level_nxt  = out_level_r;
    out_ovr_nxt    = out_ovr_r;
    mem_we         = 1'b0;
    mem_wdata      = shift_upd;

    if (cfg_valid && cfg_ready) begin
      period_nxt = (cfg_data == '0) ? PERIOD_W'(1) : cfg_data;
    end

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          now_nxt       = time_ext[TIME_BITS-1:0];
          high_nxt      = in_tdata[0];
          res_byte_nxt  = '0;
          res_valid_nxt = 1'b0;
          res_ovr_nxt   = 1'b0;
          if (in_tuser == CMD_POP) begin
            state_nxt = S_POP;
          end else if (active_r) begin
            state_nxt = S_SUB;
          end else begin
            if (!in_tdata[0]) begin
              active_nxt  = 1'b1;
              start_nxt   = time_ext[TIME_BITS-1:0];
              bit_idx_nxt = '0;
              shift_nxt   = '0;
            end
            state_nxt = S_OUT;
          end
        end
      end
      S_SUB: begin
        tph_nxt    = {1'b0, now_r - start_r} + (TIME_BITS+1)'(period_r >> 1);
        acc_nxt    = ACC_W'(period_r);
        k_nxt      = IDX_W'(1);
        target_nxt = '0;
        state_nxt  = S_CNT;
      end
      S_CNT: begin
        if (CW'(acc_r) <= CW'(tph_r)) begin
          target_nxt = target_r + 1'b1;
        end
        acc_nxt = acc_r + ACC_W'(period_r);
        if (k_r == FRAME_BITS) begin
          state_nxt = S_APPLY;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_APPLY: begin
        if (target_r > bit_idx_r) begin
          if (target_r >= FRAME_BITS) begin
            mem_we        = 1'b1;
            res_byte_nxt  = shift_upd;
            res_valid_nxt = 1'b1;
            head_nxt      = head_inc;
            if (head_inc == tail_r) begin
              tail_nxt    = tail_inc;
              res_ovr_nxt = 1'b1;
            end
            if (high_r) begin
              active_nxt = 1'b0;
            end else begin
              start_nxt = now_r;
            end
            bit_idx_nxt = '0;
            shift_nxt   = '0;
          end else begin
            bit_idx_nxt = target_r;
            shift_nxt   = shift_upd;
          end
        end
        state_nxt = S_OUT;
      end
      S_POP: begin
        if (head_r != tail_r) begin
          res_byte_nxt  = rd_data_r;
          res_valid_nxt = 1'b1;
          tail_nxt      = tail_inc;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_byte_nxt   = res_byte_r;
          out_bvalid_nxt = res_valid_r;
          out_level_nxt  = count_ext[LEVEL_W-1:0];
          out_ovr_nxt    = res_ovr_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fifo_mem[head_r] <= mem_wdata;
    end
    rd_data_r <= fifo_mem[tail_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      period_r     <= PERIOD_RESET;
      active_r     <= 1'b0;
      start_r      <= '0;
      bit_idx_r    <= '0;
      shift_r      <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      period_r     <= period_nxt;
      active_r     <= active_nxt;
      start_r      <= start_nxt;
      bit_idx_r    <= bit_idx_nxt;
      shift_r      <= shift_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r       <= now_nxt;
    high_r      <= high_nxt;
    tph_r       <= tph_nxt;
    acc_r       <= acc_nxt;
    k_r         <= k_nxt;
    target_r    <= target_nxt;
    res_byte_r  <= res_byte_nxt;
    res_valid_r <= res_valid_nxt;
    res_ovr_r   <= res_ovr_nxt;
    out_byte_r  <= out_byte_nxt;
    out_bvalid_r <= out_bvalid_nxt;
    out_level_r <= out_level_nxt;
    out_ovr_r   <= out_ovr_nxt;
  end

endmodule

// ----- rtl/etur_checker.sv -----
// ----------------------------------------------------------------------------
// Edge-timed UART receiver port checker
// Port-level checks on the receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "edge_timed_uart_receiver_core_assert.svh"

module etur_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [etur_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic                              in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [etur_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                              out_tuser,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [etur_pkg::PERIOD_W-1:0]     cfg_data
);
  import etur_pkg::*;

  `ETUR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `ETUR_ASSERT_NEXT(a_out_user_hold, out_tvalid && !out_tready, $stable(out_tuser))
  `ETUR_ASSERT_SAME(a_no_byte_zero, out_tvalid && !out_tuser, out_tdata[7:0] == 8'd0)
  `ETUR_ASSERT_SAME(a_overrun_push, out_tvalid && out_tdata[14], out_tuser)
  `ETUR_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready)

endmodule

bind edge_timed_uart_receiver_core etur_checker u_etur_checker (.*);
